// ===== src/erot_pkg.sv =====
`default_nettype none
package erot_pkg;

    // register index within the configuration space (byte address / 4)
    typedef enum logic [1:0] {
        REG_ANGLE_X = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_Z = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_FOLD,
        CS_ITER
    } t_cst;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    typedef logic signed [32:0] t_coef;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

    // atan(2^-i) * 2^30, rounded
    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic signed [34:0] r;
        r = '0;
        case (i)
            5'd0:  r = 35'sd843314857;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043837;
            5'd3:  r = 35'sd133525159;
            5'd4:  r = 35'sd67021687;
            5'd5:  r = 35'sd33543516;
            5'd6:  r = 35'sd16775851;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194283;
            5'd9:  r = 35'sd2097149;
            5'd10: r = 35'sd1048576;
            5'd11: r = 35'sd524288;
            5'd12: r = 35'sd262144;
            5'd13: r = 35'sd131072;
            5'd14: r = 35'sd65536;
            5'd15: r = 35'sd32768;
            5'd16: r = 35'sd16384;
            5'd17: r = 35'sd8192;
            5'd18: r = 35'sd4096;
            5'd19: r = 35'sd2048;
            5'd20: r = 35'sd1024;
            5'd21: r = 35'sd512;
            5'd22: r = 35'sd256;
            5'd23: r = 35'sd128;
            5'd24: r = 35'sd64;
            5'd25: r = 35'sd32;
            5'd26: r = 35'sd16;
            5'd27: r = 35'sd8;
            5'd28: r = 35'sd4;
            5'd29: r = 35'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q.30 product, round half up
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage
`default_nettype wire

// ===== src/erot_cordic.sv =====
`default_nettype none
module erot_cordic
    import erot_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_angle,
    output t_cordic_stat            o_stat,
    output logic signed [31:0]      o_sin,
    output logic signed [31:0]      o_cos
);

    t_cst r_state, n_state;
    logic [4:0] r_cnt;
    logic signed [34:0] r_a;
    logic signed [33:0] r_x, r_y;
    logic r_flip;
    logic r_done;
    logic last;
    logic signed [34:0] wide;
    logic signed [34:0] red;
    logic signed [33:0] xs, ys, cx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: if (i_start) n_state = CS_FOLD;
            CS_FOLD: n_state = CS_ITER;
            CS_ITER: if (last) n_state = CS_IDLE;
            default: n_state = CS_IDLE;
        endcase
        if (i_start) n_state = CS_FOLD;
    end

    always_comb begin
        last = (r_state == CS_ITER) && (r_cnt == 5'(CORDIC_STEPS - 1));
        o_stat.busy = (r_state != CS_IDLE);
        o_stat.done = r_done;
    end

    always_comb begin
        wide = {{1{i_angle[31]}}, i_angle, 2'b00};
        red = wide;
        if (wide > Q30_PI) red = wide - Q30_TWO_PI;
        else if (wide < -Q30_PI) red = wide + Q30_TWO_PI;
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        cx = r_flip ? -r_x : r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= last && !i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= red;
        end else if (r_state == CS_FOLD) begin
            r_x    <= CORDIC_GAIN_INV;
            r_y    <= '0;
            r_cnt  <= '0;
            r_flip <= 1'b0;
            if (r_a > Q30_HALF_PI) begin
                r_a    <= Q30_PI - r_a;
                r_flip <= 1'b1;
            end else if (r_a < -Q30_HALF_PI) begin
                r_a    <= -Q30_PI - r_a;
                r_flip <= 1'b1;
            end
        end else if (r_state == CS_ITER) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_a >= 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_a <= r_a - atan_q30(r_cnt);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_a <= r_a + atan_q30(r_cnt);
            end
        end
    end

    // clamp to the unit range
    always_comb begin
        if (r_y > Q30_ONE) o_sin = 32'sd1073741824;
        else if (r_y < -Q30_ONE) o_sin = -32'sd1073741824;
        else o_sin = r_y[31:0];
        if (cx > Q30_ONE) o_cos = 32'sd1073741824;
        else if (cx < -Q30_ONE) o_cos = -32'sd1073741824;
        else o_cos = cx[31:0];
    end

endmodule
`default_nettype wire

// ===== src/erot_matrix.sv =====
`default_nettype none
module erot_matrix
    import erot_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic signed [31:0] i_sx,
    input  wire logic signed [31:0] i_cx,
    input  wire logic signed [31:0] i_sy,
    input  wire logic signed [31:0] i_cy,
    input  wire logic signed [31:0] i_sz,
    input  wire logic signed [31:0] i_cz,
    output logic                    o_busy,
    output t_coef                   o_mat [9]
);

    logic r_v1;
    logic signed [31:0] r_sxsy, r_cxsy, r_cycz, r_cxsz, r_sxsz, r_cysz;
    logic signed [31:0] r_cxcz, r_sxcz, r_sxcy, r_cxcy, r_sy, r_sz, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= i_go;
    end

    assign o_busy = i_go || r_v1;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_sxsy <= qmul(i_sx, i_sy);
            r_cxsy <= qmul(i_cx, i_sy);
            r_cycz <= qmul(i_cy, i_cz);
            r_cxsz <= qmul(i_cx, i_sz);
            r_sxsz <= qmul(i_sx, i_sz);
            r_cysz <= qmul(i_cy, i_sz);
            r_cxcz <= qmul(i_cx, i_cz);
            r_sxcz <= qmul(i_sx, i_cz);
            r_sxcy <= qmul(i_sx, i_cy);
            r_cxcy <= qmul(i_cx, i_cy);
            r_sy   <= i_sy;
            r_sz   <= i_sz;
            r_cz   <= i_cz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            o_mat[0] <= 33'(r_cycz);
            o_mat[1] <= 33'(qmul(r_sxsy, r_cz)) - 33'(r_cxsz);
            o_mat[2] <= 33'(qmul(r_cxsy, r_cz)) + 33'(r_sxsz);
            o_mat[3] <= 33'(r_cysz);
            o_mat[4] <= 33'(qmul(r_sxsy, r_sz)) + 33'(r_cxcz);
            o_mat[5] <= 33'(qmul(r_cxsy, r_sz)) - 33'(r_sxcz);
            o_mat[6] <= -33'(r_sy);
            o_mat[7] <= 33'(r_sxcy);
            o_mat[8] <= 33'(r_cxcy);
        end
    end

endmodule
`default_nettype wire

// ===== src/erot_lane.sv =====
`default_nettype none
module erot_lane
    import erot_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_px,
    input  wire logic signed [31:0] i_py,
    input  wire logic signed [31:0] i_pz,
    input  wire t_coef              i_m0,
    input  wire t_coef              i_m1,
    input  wire t_coef              i_m2,
    output logic signed [31:0]      o_res
);

    logic signed [64:0] r_p0, r_p1, r_p2;
    logic signed [66:0] sum;
    logic signed [36:0] sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= 65'(i_px) * 65'(i_m0);
            r_p1 <= 65'(i_py) * 65'(i_m1);
            r_p2 <= 65'(i_pz) * 65'(i_m2);
        end
    end

    always_comb begin
        sum = 67'(r_p0) + 67'(r_p1) + 67'(r_p2) + 67'sd536870912;
        sh  = sum[66:30];
    end

    // saturate into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sh > 37'sd2147483647) o_res <= 32'h7FFF_FFFF;
            else if (sh < -37'sd2147483648) o_res <= 32'h8000_0000;
            else o_res <= sh[31:0];
        end
    end

endmodule
`default_nettype wire

// ===== src/euler_point_rotation.sv =====
// Euler point rotation: rotates each point by Rz*Ry*Rx using three angles.
// Input channel: i_in_valid / o_in_stall carry one point (Q16.16) per beat.
// Output channel: o_out_valid / i_out_stall carry the rotated point, saturated.
// Angles (Q3.28 radians) are written over the APB port at 0x0, 0x4 and 0x8;
// reads return the stored angle, pready is always high.
// Throughput: one point per cycle while o_in_stall is low; three row lanes
// each form one output component with three multipliers, then add, round
// and saturate; each lane registers its products, then its saturated sum.
// After reset and after every angle write, three CORDIC units (30 steps
// each, one step per cycle) and a two-stage matrix builder refresh the
// rotation matrix; o_in_stall stays high meanwhile.
// Reset clears the angles to zero and empties the pipeline.
// When i_out_stall holds the output register, the pipeline freezes and
// o_in_stall rises in the same cycle.
`default_nettype none
module euler_point_rotation
    import erot_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_rotated_x,
    output logic signed [31:0]      o_rotated_y,
    output logic signed [31:0]      o_rotated_z
);

    logic signed [31:0] r_ang_x, r_ang_y, r_ang_z;
    logic r_kick, r_v1, r_ov;
    logic cfg_wr, adv, in_acc, busy, mat_busy;
    t_cordic_stat st_x, st_y, st_z;
    logic signed [31:0] sx, cx, sy, cy, sz, cz;
    t_coef mat [9];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x <= '0;
            r_ang_y <= '0;
            r_ang_z <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ANGLE_X: r_ang_x <= pwdata;
                REG_ANGLE_Y: r_ang_y <= pwdata;
                REG_ANGLE_Z: r_ang_z <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ANGLE_X: prdata = r_ang_x;
            REG_ANGLE_Y: prdata = r_ang_y;
            REG_ANGLE_Z: prdata = r_ang_z;
            default:     prdata = '0;
        endcase
    end

    // start the matrix refresh the cycle after reset or an angle write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kick <= 1'b1;
        else r_kick <= cfg_wr;
    end

    erot_cordic u_cordic_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kick), .i_angle(r_ang_x),
        .o_stat(st_x), .o_sin(sx), .o_cos(cx)
    );
    erot_cordic u_cordic_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kick), .i_angle(r_ang_y),
        .o_stat(st_y), .o_sin(sy), .o_cos(cy)
    );
    erot_cordic u_cordic_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kick), .i_angle(r_ang_z),
        .o_stat(st_z), .o_sin(sz), .o_cos(cz)
    );

    erot_matrix u_matrix (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(st_x.done && st_y.done && st_z.done),
        .i_sx(sx), .i_cx(cx), .i_sy(sy), .i_cy(cy), .i_sz(sz), .i_cz(cz),
        .o_busy(mat_busy), .o_mat(mat)
    );

    assign busy = cfg_wr || r_kick || st_x.busy || st_y.busy || st_z.busy
                  || st_x.done || mat_busy;
    assign adv = !r_ov || !i_out_stall;
    assign o_in_stall = busy || !adv;
    assign in_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= in_acc;
            r_ov <= r_v1;
        end
    end

    assign o_out_valid = r_ov;

    erot_lane u_lane_x (
        .i_clk(i_clk), .i_en(adv), .i_px(i_point_x), .i_py(i_point_y),
        .i_pz(i_point_z), .i_m0(mat[0]), .i_m1(mat[1]), .i_m2(mat[2]),
        .o_res(o_rotated_x)
    );
    erot_lane u_lane_y (
        .i_clk(i_clk), .i_en(adv), .i_px(i_point_x), .i_py(i_point_y),
        .i_pz(i_point_z), .i_m0(mat[3]), .i_m1(mat[4]), .i_m2(mat[5]),
        .o_res(o_rotated_y)
    );
    erot_lane u_lane_z (
        .i_clk(i_clk), .i_en(adv), .i_px(i_point_x), .i_py(i_point_y),
        .i_pz(i_point_z), .i_m0(mat[6]), .i_m1(mat[7]), .i_m2(mat[8]),
        .o_res(o_rotated_z)
    );

`ifndef NO_ASSERTIONS
    a_acc_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_v1)
        else $error("accepted beat did not enter the lanes");
    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv) |=> o_out_valid)
        else $error("lane result lost before the output register");
    a_wr_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (o_in_stall && r_kick))
        else $error("angle write did not start a matrix refresh");
`endif

endmodule
`default_nettype wire
